// ===== rtl/core/iss_pkg.sv =====
package iss_pkg;

  // width of one stored element
  localparam int unsigned ValueWidth = 32;

  // default number of cells in the chain
  localparam int unsigned DefaultDepth = 16;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;  // place the broadcast value in sorted order
    logic shift;   // move every entry one place toward cell 0
  } cell_cmd_t;

endpackage

// ===== rtl/core/iss_cell.sv =====
module iss_cell (
  input  logic                                 clk_i,
  input  iss_pkg::cell_cmd_t                   cmd_i,
  input  logic                                 occupied_i,
  input  logic signed [iss_pkg::ValueWidth-1:0] ins_value_i,
  input  logic signed [iss_pkg::ValueWidth-1:0] left_value_i,
  input  logic                                 left_gt_i,
  input  logic signed [iss_pkg::ValueWidth-1:0] right_value_i,
  output logic signed [iss_pkg::ValueWidth-1:0] value_o,
  output logic                                 gt_o
);
  import iss_pkg::*;

  logic signed [ValueWidth-1:0] value_q;
  logic signed [ValueWidth-1:0] value_d;

  // empty cells act as larger than anything; equal keys stay put (stable)
  assign gt_o = !occupied_i || (value_q > ins_value_i);

  // next entry: drain from the right, or open a slot on insert
  always_comb begin
    value_d = value_q;
    if (cmd_i.shift) begin
      value_d = right_value_i;
    end else if (cmd_i.insert && gt_o) begin
      value_d = left_gt_i ? left_value_i : ins_value_i;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== rtl/core/insertion_sorter_unit.sv =====
// Stable ascending insertion sorter built as a chain of DEPTH compare cells.
// Input channel (in_valid_i / in_stall_o): one signed value per request, with
// last_i marking the final value of a set. Each request that is taken is
// broadcast to every cell and inserted in sorted order; values that find
// the chain full are dropped and flagged.
// When the last request is taken, the chain drains through cell 0: the first
// result appears the cycle after, then one result per cycle while the receiver
// does not stall, on the output channel (out_valid_o / out_stall_i): n results
// for a set of n stored values, last_res_o on the final one, overflow_o on all
// of them. The input is stalled while the chain drains, since draining uses
// the same shift path of every cell.
// When the receiver stalls, the chain holds and the current result stays.
// Reset empties the chain and clears the overflow flag; the stored entries
// themselves are not cleared.
module insertion_sorter_unit #(
  parameter int unsigned DEPTH = iss_pkg::DefaultDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [iss_pkg::ValueWidth-1:0] value_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [iss_pkg::ValueWidth-1:0] value_res_o,
  output logic                                 last_res_o,
  output logic                                 overflow_o
);
  import iss_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] remain_q, remain_d;
  logic            drain_q, drain_d;
  logic            drop_q, drop_d;
  logic            ovf_q, ovf_d;

  logic            in_acc, out_acc, full;
  cell_cmd_t       cmd;

  logic signed [ValueWidth-1:0] cell_value [DEPTH];
  logic                         cell_gt    [DEPTH];

  assign full    = (fill_q == CntW'(DEPTH));
  assign in_acc  = in_valid_i && !drain_q;
  assign out_acc = drain_q && !out_stall_i;

  assign cmd.insert = in_acc && !full;
  assign cmd.shift  = out_acc;

  // chain of compare cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValueWidth-1:0] left_value, right_value;
    logic                         left_gt;
    if (i == 0) begin : g_first
      assign left_value = value_i;
      assign left_gt    = 1'b0;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_value = '0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end
    iss_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occupied_i    (CntW'(i) < fill_q),
      .ins_value_i   (value_i),
      .left_value_i  (left_value),
      .left_gt_i     (left_gt),
      .right_value_i (right_value),
      .value_o       (cell_value[i]),
      .gt_o          (cell_gt[i])
    );
  end

  // fill, drop and drain control
  always_comb begin
    fill_d   = fill_q;
    remain_d = remain_q;
    drain_d  = drain_q;
    drop_d   = drop_q;
    ovf_d    = ovf_q;
    if (in_acc) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        fill_d = fill_q + CntW'(1);
      end
      if (last_i) begin
        remain_d = full ? fill_q : fill_q + CntW'(1);
        ovf_d    = drop_q || full;
        drain_d  = 1'b1;
        fill_d   = '0;
        drop_d   = 1'b0;
      end
    end
    if (out_acc) begin
      remain_d = remain_q - CntW'(1);
      if (remain_q == CntW'(1)) begin
        drain_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      remain_q <= '0;
      drain_q  <= 1'b0;
      drop_q   <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      remain_q <= remain_d;
      drain_q  <= drain_d;
      drop_q   <= drop_d;
      ovf_q    <= ovf_d;
    end
  end

  // outputs
  assign in_stall_o  = drain_q;
  assign out_valid_o = drain_q;
  assign value_res_o = cell_value[0];
  assign last_res_o  = (remain_q == CntW'(1));
  assign overflow_o  = ovf_q;

endmodule

// ===== rtl/core/iss_checker.sv =====
module iss_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic signed [iss_pkg::ValueWidth-1:0] value_i,
  input logic                                 last_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [iss_pkg::ValueWidth-1:0] value_res_o,
  input logic                                 last_res_o,
  input logic                                 overflow_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_res_o)
      && $stable(last_res_o) && $stable(overflow_o))
    else $error("stalled result changed");

  // no new request is taken while results drain
  a_no_input_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during drain");

  // a closing request starts the results in the next cycle
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> out_valid_o)
    else $error("set closed without results");

  // the final result ends the set
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_res_o |=> !out_valid_o)
    else $error("results continue past final");

  // results keep coming until the final one
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_res_o |=> out_valid_o)
    else $error("gap inside a set");

endmodule

bind insertion_sorter_unit iss_checker u_iss_checker (.*);
